/* src/smf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter package
// Sizes and the cell entry and position types shared by the sorter cells and the
// top level.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int unsigned WINDOW   = 5;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned MED_W    = SAMPLE_W + 1;
  localparam int unsigned AGE_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned MID      = WINDOW / 2;

  localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WINDOW - 1);

  // One slot of the sorted window: a sample and how many transfers ago it came.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [AGE_W-1:0]           age;
  } entry_t;

  // Static position of a cell in the chain.
  typedef struct packed {
    logic             first;
    logic             last;
    logic [AGE_W-1:0] rst_age;
  } cell_pos_t;

endpackage

/* src/smf_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median sorter cell
// Holds one entry of the sorted window. On each transfer it drops the oldest
// entry of the chain and takes the new sample into sorted place, working only
// from its own entry, its two neighbours and the flag passed up the chain.
// ----------------------------------------------------------------------------
module smf_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic signed [smf_pkg::SAMPLE_W-1:0] sample_i,
  input  smf_pkg::cell_pos_t             pos_i,
  input  smf_pkg::entry_t                lower_i,
  input  smf_pkg::entry_t                upper_i,
  input  logic                           del_below_i,
  output logic                           del_upto_o,
  output smf_pkg::entry_t                ent_o,
  output smf_pkg::entry_t                ent_d_o
);
  import smf_pkg::*;

  entry_t ent_q, ent_d;
  entry_t self_c, prev_c;
  logic   self_inf;
  logic   gt_self, gt_prev;

  // The oldest entry sits at or below this cell once the chain flag is set.
  assign del_upto_o = del_below_i | (ent_q.age == AGE_OLDEST);

  // View of the window with the oldest entry taken out and the rest closed up.
  always_comb begin
    self_c   = del_upto_o ? upper_i : ent_q;
    self_inf = del_upto_o & pos_i.last;
    prev_c   = del_below_i ? ent_q : lower_i;
    gt_self  = self_inf | (self_c.value > sample_i);
    gt_prev  = ~pos_i.first & (prev_c.value > sample_i);
  end

  always_comb begin
    ent_d = ent_q;
    if (shift_i) begin
      if (!gt_self) begin
        ent_d.value = self_c.value;
        ent_d.age   = self_c.age + AGE_W'(1);
      end else if (!gt_prev) begin
        ent_d.value = sample_i;
        ent_d.age   = '0;
      end else begin
        ent_d.value = prev_c.value;
        ent_d.age   = prev_c.age + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.value <= '0;
      ent_q.age   <= pos_i.rst_age;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o   = ent_q;
  assign ent_d_o = ent_d;

endmodule

/* src/sliding_window_median_filter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter core
// Median of the last WINDOW samples, returned doubled, from a sorted cell chain.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle while in_ready_o is high and
// returns, in the cycle after its transfer, twice the median of the last
// WINDOW samples (window starts as all zeros after reset). The window is kept
// sorted in a chain of cells, each holding a value and its age; every transfer
// removes the oldest entry and inserts the new sample in the same cycle, so the
// sustained rate is one item per cycle whenever the result register is free or
// being drained. The cycle time is set by the oldest-entry flag rippling
// through the cells, followed by the compare and select inside each cell and,
// for an even window only, the adder that sums the two middle entries.
module sliding_window_median_filter_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [smf_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [smf_pkg::MED_W-1:0]     median_doubled_o
);
  import smf_pkg::*;

  logic   in_fire;
  entry_t ent    [WINDOW];
  entry_t ent_d  [WINDOW];
  entry_t lower  [WINDOW];
  entry_t upper  [WINDOW];
  logic   del_in [WINDOW];
  logic   del_out[WINDOW];

  logic signed [MED_W-1:0] med_d, med_q;
  logic                    out_valid_q;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    cell_pos_t pos;

    assign pos.first   = 1'(i == 0);
    assign pos.last    = 1'(i == WINDOW - 1);
    assign pos.rst_age = AGE_W'(i);

    if (i == 0) begin : g_lo_edge
      assign lower[i]  = '0;
      assign del_in[i] = 1'b0;
    end else begin : g_lo
      assign lower[i]  = ent[i-1];
      assign del_in[i] = del_out[i-1];
    end

    if (i == WINDOW - 1) begin : g_up_edge
      assign upper[i] = '0;
    end else begin : g_up
      assign upper[i] = ent[i+1];
    end

    smf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (in_fire),
      .sample_i   (sample_i),
      .pos_i      (pos),
      .lower_i    (lower[i]),
      .upper_i    (upper[i]),
      .del_below_i(del_in[i]),
      .del_upto_o (del_out[i]),
      .ent_o      (ent[i]),
      .ent_d_o    (ent_d[i])
    );
  end

  if (WINDOW % 2 == 1) begin : g_odd
    assign med_d = {ent_d[MID].value, 1'b0};
  end else begin : g_even
    assign med_d = MED_W'(ent_d[MID-1].value) + MED_W'(ent_d[MID].value);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      med_q <= med_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;

  // Checks on the cell chain.
  logic [WINDOW-1:0] oldest_vec;
  logic [WINDOW-1:0] sorted_vec;

  for (genvar i = 0; i < WINDOW; i++) begin : g_chk
    assign oldest_vec[i] = (ent[i].age == AGE_OLDEST);
    if (i == 0) begin : g_first
      assign sorted_vec[i] = 1'b1;
    end else begin : g_rest
      assign sorted_vec[i] = (ent[i-1].value <= ent[i].value);
    end
  end

  a_one_oldest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(oldest_vec))
    else $error("window does not hold exactly one oldest entry");

  a_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    &sorted_vec)
    else $error("cell chain is out of order");

  a_chain_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    del_out[WINDOW-1])
    else $error("oldest entry not found along the chain");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("no result after an input transfer");

endmodule

/* bench/sliding_window_median_filter_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median filter core testbench
// The bench drives signed samples into the core over the valid/ready input
// channel and keeps its own copy of the sample window to predict each doubled
// median. Every result transfer is compared with the oldest prediction. The
// stimulus starts with field extremes and zero-filled start-up windows, then
// runs random segments of wide noise, clustered values, extremes and slow
// drifts. Both channels stall at random, except near the end of the run.
// ----------------------------------------------------------------------------

class median_scoreboard;
  logic signed [smf_pkg::SAMPLE_W-1:0] window_q [smf_pkg::WINDOW];
  logic signed [smf_pkg::MED_W-1:0]    pending_medians [$];
  int unsigned                         mismatches;
  int unsigned                         medians_checked;

  function new();
    foreach (window_q[i]) window_q[i] = '0;
    mismatches      = 0;
    medians_checked = 0;
  endfunction

  // Shifts the sample into the window and queues twice the window median.
  function void note_sample(input logic signed [smf_pkg::SAMPLE_W-1:0] sample);
    logic signed [smf_pkg::SAMPLE_W-1:0] ordered [smf_pkg::WINDOW];
    logic signed [smf_pkg::SAMPLE_W-1:0] key;
    logic signed [smf_pkg::MED_W-1:0]    lower;
    logic signed [smf_pkg::MED_W-1:0]    upper;
    int                                  i;
    int                                  j;
    int                                  lower_idx;
    for (i = smf_pkg::WINDOW - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = sample;
    foreach (window_q[k]) ordered[k] = window_q[k];
    for (i = 1; i < smf_pkg::WINDOW; i++) begin
      key = ordered[i];
      j   = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j+1] = ordered[j];
        j--;
      end
      ordered[j+1] = key;
    end
    // For an odd window both halves are the middle entry, giving twice the median.
    lower_idx = (smf_pkg::WINDOW % 2 == 1) ? smf_pkg::MID : smf_pkg::MID - 1;
    lower     = ordered[lower_idx];
    upper     = ordered[smf_pkg::MID];
    pending_medians.push_back(lower + upper);
  endfunction

  function void check_median(input logic signed [smf_pkg::MED_W-1:0] got);
    logic signed [smf_pkg::MED_W-1:0] want;
    if (pending_medians.size() == 0) begin
      $display("%0t: unexpected median_doubled %0d with no prediction waiting",
               $time, got);
      mismatches++;
    end else begin
      want = pending_medians.pop_front();
      medians_checked++;
      if (got !== want) begin
        $display("%0t: median_doubled expected %0d, got %0d", $time, want, got);
        mismatches++;
      end
    end
  endfunction

  function int unsigned pending_count();
    return pending_medians.size();
  endfunction
endclass

module sliding_window_median_filter_core_tb;

  localparam int unsigned RANDOM_ITEMS  = 650;
  localparam int unsigned CALM_ITEMS    = 100;
  localparam int unsigned DIRECTED_LEN  = 20;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;

  localparam logic signed [smf_pkg::SAMPLE_W-1:0] EXTREMES [DIRECTED_LEN] = '{
    16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
    16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
    16'h0001, 16'hFFFF, 16'h0000, 16'h7FFE, 16'h8001
  };

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic signed [smf_pkg::SAMPLE_W-1:0]  sample_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i;
  logic signed [smf_pkg::MED_W-1:0]     median_doubled_o;

  median_scoreboard sb;
  bit               stalls_on;
  int unsigned      samples_sent;

  sliding_window_median_filter_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .median_doubled_o (median_doubled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  // Both transfers are observed on the same edge; a result always stems from an
  // earlier input transfer, so the order of the two calls does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_median(median_doubled_o);
      if (in_valid_i && in_ready_o) begin
        sb.note_sample(sample_i);
        samples_sent++;
      end
    end
  end

  // Result side back-pressure in short bursts.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stalls_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_sample(input logic signed [smf_pkg::SAMPLE_W-1:0] value);
    if (stalls_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      sample_i   <= smf_pkg::SAMPLE_W'($urandom);
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned                         n;
    int unsigned                         seg_len;
    int unsigned                         mode;
    int                                  drift;
    logic signed [smf_pkg::SAMPLE_W-1:0] value;

    sb           = new();
    samples_sent = 0;
    stalls_on    = 1'b1;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    sample_i     = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The first few transfers see a window still padded with reset zeros.
    foreach (EXTREMES[i]) send_sample(EXTREMES[i]);

    n     = 0;
    drift = 0;
    while (n < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(8, 40);
      drift   = $urandom_range(0, 65535) - 32768;
      repeat (seg_len) begin
        if (n < RANDOM_ITEMS) begin
          stalls_on = (n < RANDOM_ITEMS - CALM_ITEMS);
          case (mode)
            0: value = smf_pkg::SAMPLE_W'($urandom);
            // Clustered values produce plenty of ties in the window.
            1: value = smf_pkg::SAMPLE_W'($urandom_range(0, 15) - 8);
            2: begin
              case ($urandom_range(0, 3))
                0: value = 16'h7FFF;
                1: value = 16'h8000;
                2: value = 16'hFFFF;
                default: value = 16'h0000;
              endcase
            end
            default: begin
              drift = drift + $urandom_range(0, 512) - 256;
              if (drift > 32767)  drift = 32767;
              if (drift < -32768) drift = -32768;
              value = smf_pkg::SAMPLE_W'(drift);
            end
          endcase
          send_sample(value);
          n++;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d samples: extremes, start-up windows, noise, ties and drifts.",
             samples_sent);
    $display("Checked %0d doubled medians with %0d mismatches.",
             sb.medians_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
